// File: rtl/core/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

  // Default sizing of the corner store and the coordinate datapath.
  localparam int MAX_CORNERS_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  // Fixed widths of the channel fields and the configuration register.
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register index of the corner count.
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Count in use after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd3;

  // Input item kinds.
  typedef enum logic {
    ACT_VERTEX = 1'b0,
    ACT_TEST   = 1'b1
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the test point and clear the crossing flag
    logic wr_en;     // write one corner into the store
    logic rd_en;     // read one corner from the store
    logic rd_edge;   // the read corner closes an edge with the previous one
    logic load_res;  // copy the crossing flag into the result register
  } cmd_t;

endpackage

// File: rtl/core/pip_if.sv
`timescale 1ns / 1ps

// Input channel: vertex writes and point tests.
interface pip_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [pip_pkg::SLOT_W-1:0]       vertex_index;
  logic signed [pip_pkg::COORD_W-1:0] coord_x;
  logic signed [pip_pkg::COORD_W-1:0] coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

// Output channel: one inside flag per point test.
interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// File: rtl/core/point_in_polygon_test.sv
`timescale 1ns / 1ps

// Even-odd ray-crossing point-in-polygon test.
// Input channel in_i carries items of two kinds. A vertex write (action 0)
// stores one corner at vertex_index and produces no result.
// A point test (action 1) walks the ring of the first vertex_count corners,
// one edge per cycle from the store's single read port, and returns one
// inside_res item on out_o.
// A point test's result becomes valid once the walk (one store read per corner)
// and the edge and product stages have finished, and the next item can be
// accepted from that cycle on; a count of zero skips the walk. Corners must be
// written before they are used.
// vertex_count is written over the APB port at byte address 0; it may only
// change while no point test is in flight. Counts above the store depth
// saturate to it.
// Reset clears the sequencer and sets vertex_count to 3; the corner store
// keeps no reset value. If the receiver stalls, the result stays in the
// output register; vertex writes and the next test are still accepted, and
// a finished test waits until the older result has been taken.
module point_in_polygon_test #(
  parameter int MAX_CORNERS = pip_pkg::MAX_CORNERS_DEF,
  parameter int COORD_BITS  = pip_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pip_in_if.sink                      in_i,
  pip_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pip_pkg::APB_AW-1:0]  paddr,
  input  logic [pip_pkg::APB_DW-1:0]  pwdata,
  output logic [pip_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  import pip_pkg::*;

  localparam int AW = $clog2(MAX_CORNERS);

  logic [COUNT_W-1:0] count_q;
  logic               reg_sel;
  cmd_t               cmd;
  logic [AW-1:0]      rd_addr;
  logic               busy;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(APB_DW - COUNT_W){1'b0}}, count_q} : '0;

  pip_ctrl #(
    .MAX_CORNERS (MAX_CORNERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_slot_i   (in_i.vertex_index),
    .count_i     (count_q),
    .out_ready_i (out_o.ready),
    .busy_i      (busy),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  pip_dpath #(
    .MAX_CORNERS (MAX_CORNERS),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .slot_i       (in_i.vertex_index),
    .coord_x_i    (in_i.coord_x),
    .coord_y_i    (in_i.coord_y),
    .busy_o       (busy),
    .inside_res_o (out_o.inside_res)
  );

endmodule

// File: rtl/core/pip_ram.sv
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pip_dpath.sv
`timescale 1ns / 1ps

module pip_dpath #(
  parameter int MAX_CORNERS = pip_pkg::MAX_CORNERS_DEF,
  parameter int COORD_BITS  = pip_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pip_pkg::cmd_t                    cmd_i,
  input  logic [$clog2(MAX_CORNERS)-1:0]   rd_addr_i,
  input  logic [pip_pkg::SLOT_W-1:0]       slot_i,
  input  logic [pip_pkg::COORD_W-1:0]      coord_x_i,
  input  logic [pip_pkg::COORD_W-1:0]      coord_y_i,
  output logic                             busy_o,
  output logic                             inside_res_o
);

  import pip_pkg::*;

  localparam int AW = $clog2(MAX_CORNERS);
  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Test point.
  logic signed [CB-1:0] px_q, py_q;

  // Store read tag and the corner read before the current one.
  logic          rd_vld_q, rd_edge_q;
  logic [2*CB-1:0] rdata;
  logic [2*CB-1:0] prev_q;

  // Edge stage.
  logic signed [CB-1:0] xi, yi, xj, yj;
  logic                 straddle;
  logic signed [DW-1:0] lx_d, dy_d, ex_d, ey_d;
  logic signed [DW-1:0] lx_q, dy_q, ex_q, ey_q;
  logic                 s1_vld_q, s1_up_q;

  // Product stage.
  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic                 s2_vld_q, s2_up_q;
  logic                 hit;

  logic inside_q, res_q;

  pip_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_CORNERS)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (AW'(slot_i)),
    .wdata_i ({coord_y_i[CB-1:0], coord_x_i[CB-1:0]}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // Current corner i from the store, previous corner j from the holding register.
  assign xi = rdata[CB-1:0];
  assign yi = rdata[2*CB-1:CB];
  assign xj = prev_q[CB-1:0];
  assign yj = prev_q[2*CB-1:CB];

  // The edge straddles the point's y when exactly one end lies above it.
  assign straddle = (yi > py_q) != (yj > py_q);

  // Exact differences, one bit wider than a coordinate.
  assign lx_d = {px_q[CB-1], px_q} - {xi[CB-1], xi};
  assign dy_d = {yj[CB-1], yj} - {yi[CB-1], yi};
  assign ex_d = {xj[CB-1], xj} - {xi[CB-1], xi};
  assign ey_d = {py_q[CB-1], py_q} - {yi[CB-1], yi};

  // Cross products of the crossing test.
  assign pa_d = lx_q * dy_q;
  assign pb_d = ex_q * ey_q;

  // The compare sense flips when the edge runs downward.
  assign hit = s2_up_q ? (pa_q < pb_q) : (pb_q < pa_q);

  // Payload registers of the pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= coord_x_i[CB-1:0];
      py_q <= coord_y_i[CB-1:0];
    end
    if (rd_vld_q) begin
      prev_q <= rdata;
    end
    lx_q    <= lx_d;
    dy_q    <= dy_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    s1_up_q <= ~dy_d[DW-1];
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    s2_up_q <= s1_up_q;
    if (cmd_i.load_res) begin
      res_q <= inside_q;
    end
  end

  // Stage valids and the crossing flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_edge_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      inside_q  <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      rd_edge_q <= cmd_i.rd_edge;
      s1_vld_q  <= rd_vld_q & rd_edge_q & straddle;
      s2_vld_q  <= s1_vld_q;
      if (cmd_i.start) begin
        inside_q <= 1'b0;
      end else if (s2_vld_q && hit) begin
        inside_q <= ~inside_q;
      end
    end
  end

  assign busy_o       = rd_vld_q | s1_vld_q | s2_vld_q;
  assign inside_res_o = res_q;

`ifndef ASSERT_OFF
  // An edge only enters the edge stage after a store read that closed an edge.
  a_s1_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(rd_vld_q) && $past(rd_edge_q))
    else $error("edge stage loaded without an edge read");

  // The crossing flag never moves while a result is copied out.
  a_flag_stable_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_res |-> !s2_vld_q)
    else $error("result loaded while the pipeline still toggles");

  // The result register follows the flag on a load.
  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_res |=> res_q == $past(inside_q))
    else $error("result register did not take the crossing flag");
`endif

endmodule

// File: rtl/core/pip_ctrl.sv
`timescale 1ns / 1ps

module pip_ctrl #(
  parameter int MAX_CORNERS = pip_pkg::MAX_CORNERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_action_i,
  input  logic [pip_pkg::SLOT_W-1:0]     in_slot_i,
  input  logic [pip_pkg::COUNT_W-1:0]    count_i,
  input  logic                           out_ready_i,
  input  logic                           busy_i,
  output pip_pkg::cmd_t                  cmd_o,
  output logic [$clog2(MAX_CORNERS)-1:0] rd_addr_o,
  output logic                           in_ready_o,
  output logic                           out_valid_o
);

  import pip_pkg::*;

  localparam int AW   = $clog2(MAX_CORNERS);
  localparam int CMPW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   idx_q, last_q;
  logic            out_valid_q;

  logic            accept, is_test, slot_ok;
  logic [CMPW-1:0] cnt_ext, n_eff;
  logic [AW-1:0]   last;
  logic            n_zero;

  // Corners in use, saturated to the store depth.
  assign cnt_ext = CMPW'(count_i);
  assign n_eff   = (cnt_ext > CMPW'(MAX_CORNERS)) ? CMPW'(MAX_CORNERS) : cnt_ext;
  assign n_zero  = (n_eff == '0);
  assign last    = AW'(n_eff - CMPW'(1));

  // Input items are taken only between point tests.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign is_test    = (in_action_i == ACT_TEST);
  assign slot_ok    = ({{(32 - SLOT_W){1'b0}}, in_slot_i} < 32'(MAX_CORNERS));

  // Commands to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = accept & is_test;
    cmd_o.wr_en    = accept & ~is_test & slot_ok;
    cmd_o.rd_en    = (state_q == ST_PRIME) || (state_q == ST_WALK);
    cmd_o.rd_edge  = (state_q == ST_WALK);
    cmd_o.load_res = (state_q == ST_DRAIN) && !busy_i && (!out_valid_q || out_ready_i);
    rd_addr_o      = (state_q == ST_PRIME) ? last_q : idx_q;
  end

  // Sequencer: read the last corner first, then walk corners zero upward.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            last_q  <= last;
            idx_q   <= '0;
            state_q <= n_zero ? ST_DRAIN : ST_PRIME;
          end
        end
        ST_PRIME: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          idx_q <= idx_q + AW'(1);
          if (idx_q == last_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cmd_o.load_res) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // A store read keeps the datapath busy in the next cycle.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> busy_i)
    else $error("store read did not mark the datapath busy");

  // The walk ends right after the last corner is read.
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && (idx_q == last_q) |=> state_q == ST_DRAIN)
    else $error("walk did not stop at the last corner");

  // A loaded result is offered in the next cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_res |=> out_valid_o)
    else $error("loaded result not offered");

  // The pipeline is empty whenever new items are taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !busy_i)
    else $error("datapath busy while idle");
`endif

endmodule

// File: sim/point_in_polygon_test_test.sv
`timescale 1ns / 1ps

module point_in_polygon_test_test;
  import pip_pkg::*;

  localparam int CORNERS     = MAX_CORNERS_DEF;
  localparam int PAD_W       = APB_DW - COUNT_W;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_GAP   = 96;
  localparam int HOLD_SPAN   = 500;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 48;
  localparam int HOLD_PHASE  = 7;

  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  // Coordinate spreads used to build polygons and probe points.
  typedef enum int {SPAN_SMALL, SPAN_MID, SPAN_FULL, SPAN_EXTREME} span_e;

  typedef struct {
    action_e                    action;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } pip_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  pip_in_if  pts_if ();
  pip_out_if flag_if ();

  point_in_polygon_test dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pts_if),
    .out_o   (flag_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the corner ring and the count in use.
  logic signed [COORD_W-1:0] ring_x [CORNERS];
  logic signed [COORD_W-1:0] ring_y [CORNERS];
  int                        ring_count;

  // Generator view of the ring, used to keep every probed corner written.
  bit                        slot_planned [CORNERS];
  logic signed [COORD_W-1:0] plan_x [CORNERS];
  logic signed [COORD_W-1:0] plan_y [CORNERS];
  int                        plan_corners;
  int                        items_queued;

  pip_item_t pending_items [$];
  bit        expected_flags [$];

  pip_item_t offered;
  bit        offering;
  int        send_wait;
  int        stall_left;
  int        hold_left;
  bit        hold_request;
  bit        sender_burst;
  bit        receiver_burst;
  int        mismatches;
  int        quiet_cycles;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void report_fault(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Even-odd crossing count over the ring, exact at 80 bits.
  function automatic bit ring_parity(logic signed [COORD_W-1:0] px,
                                     logic signed [COORD_W-1:0] py);
    int n;
    int j;
    bit odd;
    logic signed [COORD_W-1:0] xi, yi, xj, yj;
    logic signed [79:0] lx, ex, ey, dy, lhs, rhs;
    odd = 1'b0;
    n = (ring_count > CORNERS) ? CORNERS : ring_count;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = ring_x[i];
      yi = ring_y[i];
      xj = ring_x[j];
      yj = ring_y[j];
      if ((yi > py) != (yj > py)) begin
        dy = yj - yi;
        lx = px - xi;
        ex = xj - xi;
        ey = py - yi;
        lhs = lx * dy;
        rhs = ex * ey;
        // The sense of the comparison follows the edge direction.
        if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) begin
          odd = !odd;
        end
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic void absorb_item(pip_item_t it);
    if (it.action == ACT_VERTEX) begin
      ring_x[it.slot] = it.x;
      ring_y[it.slot] = it.y;
    end else begin
      expected_flags.push_back(ring_parity(it.x, it.y));
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(span_e s);
    logic [31:0] r;
    r = $urandom;
    case (s)
      SPAN_SMALL: return 32'($urandom_range(0, 40)) - 32'sd20;
      SPAN_MID:   return {{16{r[15]}}, r[15:0]};
      SPAN_FULL:  return r;
      default: begin
        case ($urandom_range(0, 5))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 32'sd0;
          3:       return -32'sd1;
          4:       return 32'sd1;
          default: return C_MIN + 32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic span_e pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return SPAN_SMALL;
    end else if (r < 7) begin
      return SPAN_MID;
    end else if (r < 9) begin
      return SPAN_FULL;
    end
    return SPAN_EXTREME;
  endfunction

  function automatic void queue_item(action_e act, logic [SLOT_W-1:0] slot,
                                     logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y);
    pip_item_t it;
    it.action = act;
    it.slot   = slot;
    it.x      = x;
    it.y      = y;
    pending_items.push_back(it);
    items_queued++;
    if (act == ACT_VERTEX) begin
      slot_planned[slot] = 1'b1;
      plan_x[slot] = x;
      plan_y[slot] = y;
    end
  endfunction

  function automatic void queue_ring(span_e s);
    for (int k = 0; k < plan_corners; k++) begin
      queue_item(ACT_VERTEX, SLOT_W'(k), pick_coord(s), pick_coord(s));
    end
  endfunction

  // A point test; missing corners of the ring are written first, and the
  // point often shares a y or a whole position with a corner.
  function automatic void queue_probe(span_e s);
    logic signed [COORD_W-1:0] px, py;
    int pick;
    for (int k = 0; k < plan_corners; k++) begin
      if (!slot_planned[k]) begin
        queue_item(ACT_VERTEX, SLOT_W'(k), pick_coord(s), pick_coord(s));
      end
    end
    px = pick_coord(s);
    py = pick_coord(s);
    if (plan_corners > 0 && $urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, plan_corners - 1);
      py = plan_y[pick];
      if ($urandom_range(0, 1) == 1) begin
        px = plan_x[pick];
      end
    end
    queue_item(ACT_TEST, SLOT_W'($urandom), px, py);
  endfunction

  // Mostly whole polygons followed by probes, with stray writes and tests.
  function automatic void build_phase(int budget);
    int goal;
    span_e s;
    goal = items_queued + budget;
    while (items_queued < goal) begin
      s = pick_span();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          queue_ring(s);
          repeat ($urandom_range(2, 8)) queue_probe(s);
        end
        6, 7: queue_item(ACT_VERTEX, SLOT_W'($urandom), pick_coord(s), pick_coord(s));
        default: queue_probe(s);
      endcase
    end
  endfunction

  // Wait until every item has gone in and every flag has come back.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || pts_if.valid || expected_flags.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // Write the corner count, then read it back.
  task automatic set_corner_count(logic [COUNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    pwdata  <= {PAD_W'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    ring_count = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[COUNT_W-1:0] !== value) begin
      report_fault($sformatf("count readback: expected %0d, got %0d",
                             value, prdata[COUNT_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    plan_corners = (value > CORNERS) ? CORNERS : value;
  endtask

  // Driver: offers queued items, with a randomly drawn wait between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_if.valid <= 1'b0;
      offering = 1'b0;
      send_wait = 0;
    end else begin
      if (pts_if.valid && pts_if.ready) begin
        absorb_item(offered);
        offering = 1'b0;
        send_wait = draw_wait(sender_burst);
      end
      if (!offering) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          offering = 1'b1;
          pts_if.action       <= offered.action;
          pts_if.vertex_index <= offered.slot;
          pts_if.coord_x      <= offered.x;
          pts_if.coord_y      <= offered.y;
        end
      end
      pts_if.valid <= offering;
    end
  end

  // Monitor: checks each flag against the oldest expectation and stalls
  // at random, or for one long stretch on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_if.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (flag_if.valid && flag_if.ready) begin
        if (expected_flags.size() == 0) begin
          report_fault($sformatf("unexpected result, inside_res %b", flag_if.inside_res));
        end else if (flag_if.inside_res !== expected_flags[0]) begin
          report_fault($sformatf("inside_res: expected %b, got %b",
                                 expected_flags[0], flag_if.inside_res));
          void'(expected_flags.pop_front());
        end else begin
          void'(expected_flags.pop_front());
        end
        stall_left = draw_wait(receiver_burst);
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (flag_if.valid && stall_left > 0) begin
        stall_left--;
      end
      if (hold_request) begin
        hold_left = HOLD_SPAN;
        hold_request = 1'b0;
      end
      flag_if.ready <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((pts_if.valid && pts_if.ready) || (flag_if.valid && flag_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [COUNT_W-1:0] next_count;
    int first_counts [6];
    first_counts = '{0, 1, 2, 64, 127, 3};
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    pts_if.valid        = 1'b0;
    pts_if.action       = ACT_VERTEX;
    pts_if.vertex_index = '0;
    pts_if.coord_x      = '0;
    pts_if.coord_y      = '0;
    flag_if.ready       = 1'b0;
    hold_request   = 1'b0;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    mismatches     = 0;
    items_queued   = 0;
    ring_count     = COUNT_RESET;
    plan_corners   = COUNT_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Small triangle with a horizontal base, on the count left by reset.
    queue_item(ACT_VERTEX, 6'd0, -32'sd10, -32'sd10);
    queue_item(ACT_VERTEX, 6'd1, 32'sd10, -32'sd10);
    queue_item(ACT_VERTEX, 6'd2, 32'sd0, 32'sd10);
    queue_item(ACT_TEST, 6'd0, 32'sd0, 32'sd0);
    queue_item(ACT_TEST, 6'd5, 32'sd0, -32'sd10);
    queue_item(ACT_TEST, 6'd9, 32'sd0, 32'sd10);
    queue_item(ACT_TEST, 6'd0, -32'sd30, 32'sd0);
    queue_item(ACT_TEST, 6'd0, 32'sd30, 32'sd0);
    queue_item(ACT_TEST, 6'd0, 32'sd0, -32'sd11);
    // Triangle spanning the whole coordinate range, and the top slot.
    queue_item(ACT_VERTEX, 6'd0, C_MIN, C_MIN);
    queue_item(ACT_VERTEX, 6'd1, C_MAX, C_MIN);
    queue_item(ACT_VERTEX, 6'd2, 32'sd0, C_MAX);
    queue_item(ACT_VERTEX, 6'd63, -32'sd1, -32'sd1);
    queue_item(ACT_TEST, 6'd63, 32'sd0, 32'sd0);
    queue_item(ACT_TEST, 6'd0, C_MAX, C_MAX);
    queue_item(ACT_TEST, 6'd0, C_MIN, 32'sd0);
    queue_item(ACT_TEST, 6'd0, -32'sd1, -32'sd1);
    queue_item(ACT_TEST, 6'd0, C_MAX, C_MIN);
    settle();

    // Random phases, each on its own corner count.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        next_count = COUNT_W'(first_counts[p]);
      end else if ($urandom_range(0, 3) != 0) begin
        next_count = COUNT_W'($urandom_range(3, 12));
      end else begin
        next_count = COUNT_W'($urandom_range(0, 127));
      end
      set_corner_count(next_count);
      @(negedge clk_i);
      sender_burst   = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      // One phase keeps offering items while the receiver holds off.
      if (p == HOLD_PHASE) begin
        sender_burst = 1'b1;
        hold_request = 1'b1;
      end
      build_phase(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0 && expected_flags.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
